/* rtl/core/tdr_pkg.sv */
// ----------------------------------------------------------------------------
// tdr_pkg
// Shared types, widths, codes and helpers for the threshold duration
// recursion core.
// ----------------------------------------------------------------------------
`default_nettype none

package tdr_pkg;

    localparam int VAL_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int OP_W       = 2;
    localparam int KIND_W     = 2;
    localparam int LAG_W      = 2;
    localparam int SLOT_W     = 3;
    localparam int REGIME_W   = 3;
    localparam int ORDER_W    = 3;
    localparam int BURN_W     = 16;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int RND_W      = PROD_W - FRAC_W;
    localparam int ACC_W      = 56;

    localparam int MAX_P_DEF           = 4;
    localparam int MAX_Q_DEF           = 4;
    localparam int MAX_BREAKPOINTS_DEF = 7;

    typedef logic signed [VAL_W-1:0] q16_t;

    localparam q16_t ONE_Q16 = q16_t'(1 << FRAC_W);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FRAC_W - 1));

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_COEF = 2'd0,
        OP_LOAD_BP   = 2'd1,
        OP_PUSH      = 2'd2,
        OP_STEP      = 2'd3
    } opcode_t;

    localparam logic [KIND_W-1:0] KIND_OMEGA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALPHA = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BETA  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_Q      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BP_COUNT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BURN_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 3'd4;

    typedef struct packed {
        logic mul_vld;
        logic clear;
    } mac_ctl_t;

    function automatic q16_t sat_q16(input logic signed [ACC_W-1:0] v);
        logic hi_same;
        hi_same = (v[ACC_W-1:VAL_W-1] == '0) || (v[ACC_W-1:VAL_W-1] == '1);
        if (hi_same)
            return v[VAL_W-1:0];
        else if (v[ACC_W-1])
            return {1'b1, {(VAL_W-1){1'b0}}};
        else
            return {1'b0, {(VAL_W-1){1'b1}}};
    endfunction

endpackage

`default_nettype wire

/* rtl/core/tdr_item_if.sv */
// ----------------------------------------------------------------------------
// tdr_item_if
// Input item channel: opcode beat with coefficient, breakpoint, start pair
// or innovation payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdr_item_if;
    logic                            valid;
    logic                            ready;
    logic [tdr_pkg::OP_W-1:0]        opcode;
    logic [tdr_pkg::KIND_W-1:0]      coef_kind;
    logic [tdr_pkg::LAG_W-1:0]       lag;
    logic [tdr_pkg::SLOT_W-1:0]      slot;
    logic signed [tdr_pkg::VAL_W-1:0] value_a;
    logic signed [tdr_pkg::VAL_W-1:0] value_b;

    modport source (output valid, opcode, coef_kind, lag, slot, value_a, value_b,
                    input ready);
    modport sink (input valid, opcode, coef_kind, lag, slot, value_a, value_b,
                  output ready);
    modport monitor (input valid, ready, opcode, coef_kind, lag, slot, value_a, value_b);
endinterface

`default_nettype wire

/* rtl/core/tdr_result_if.sv */
// ----------------------------------------------------------------------------
// tdr_result_if
// Result channel: one duration beat with its regime and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdr_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [tdr_pkg::VAL_W-1:0] duration;
    logic [tdr_pkg::REGIME_W-1:0]     regime;
    logic                             last_result;

    modport source (output valid, duration, regime, last_result, input ready);
    modport sink (input valid, duration, regime, last_result, output ready);
    modport monitor (input valid, ready, duration, regime, last_result);
endinterface

`default_nettype wire

/* rtl/core/tdr_cfg_if.sv */
// ----------------------------------------------------------------------------
// tdr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface tdr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [tdr_pkg::CFG_IDX_W-1:0]     index;
    logic [tdr_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
    modport monitor (input valid, ready, index, data);
endinterface

`default_nettype wire

/* rtl/core/tdr_ram.sv */
// ----------------------------------------------------------------------------
// tdr_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tdr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/tdr_mac.sv */
// ----------------------------------------------------------------------------
// tdr_mac
// Shared Q16.16 multiply-accumulate unit: registered product, round to
// nearest (ties up), exact wide accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module tdr_mac (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire tdr_pkg::mac_ctl_t                     ctl,
    input  wire tdr_pkg::q16_t                         a,
    input  wire tdr_pkg::q16_t                         b,
    output logic signed [tdr_pkg::ACC_W-1:0]           acc,
    output logic signed [tdr_pkg::RND_W-1:0]           rnd,
    output logic                                       prod_vld
);

    logic signed [tdr_pkg::PROD_W-1:0] prod_reg;
    logic                              prod_vld_reg;
    logic signed [tdr_pkg::ACC_W-1:0]  acc_reg;
    logic signed [tdr_pkg::PROD_W-1:0] rsum;

    assign rsum     = prod_reg + signed'(tdr_pkg::ROUND_HALF);
    assign rnd      = rsum[tdr_pkg::PROD_W-1:tdr_pkg::FRAC_W];
    assign acc      = acc_reg;
    assign prod_vld = prod_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg     <= '0;
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= ctl.mul_vld;
            if (ctl.mul_vld)
            begin
                prod_reg <= a * b;
            end
            if (ctl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + tdr_pkg::ACC_W'(rnd);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/threshold_duration_recursion_core.sv */
// ----------------------------------------------------------------------------
// threshold_duration_recursion_core
// Regime-switching duration recursion in signed Q16.16.
//
// Channels: item (sink) takes opcode beats: load coefficient, load
// breakpoint, push start pair, step. result (source) gives duration,
// regime and last_result. cfg (sink) writes order_p, order_q,
// breakpoint_count, burn_count, output_count; always ready.
// Coefficients sit in a RAM of (MAX_BREAKPOINTS+1)*(1+MAX_P+MAX_Q) words,
// breakpoints in a RAM of MAX_BREAKPOINTS words; both read one per cycle.
// Loads keep item ready high. A push passes straight to the emit state.
// A step with nb breakpoints and p, q lags does one breakpoint read per
// cycle, then one coefficient read and one multiply on the shared MAC per
// cycle, then the final mu*e multiply.
// Results sit in an output register; the next item is accepted while a
// result waits. If the register is still full when a new result is ready,
// the core holds that result until the receiver takes the old one.
// Reset clears histories, counters and the output valid and loads the
// config defaults; table contents are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module threshold_duration_recursion_core #(
    parameter int MAX_P           = tdr_pkg::MAX_P_DEF,
    parameter int MAX_Q           = tdr_pkg::MAX_Q_DEF,
    parameter int MAX_BREAKPOINTS = tdr_pkg::MAX_BREAKPOINTS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tdr_item_if.sink     item,
    tdr_result_if.source result,
    tdr_cfg_if.sink      cfg
);

    localparam int REGIMES    = MAX_BREAKPOINTS + 1;
    localparam int PER_REGIME = 1 + MAX_P + MAX_Q;
    localparam int COEF_DEPTH = REGIMES * PER_REGIME;
    localparam int CAW        = $clog2(COEF_DEPTH);
    localparam int BAW        = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
    localparam int RW         = $clog2(REGIMES);
    localparam int TW         = $clog2(PER_REGIME + 1);
    localparam int PW         = $clog2(MAX_P + 1);
    localparam int QW         = $clog2(MAX_Q + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BP,
        S_COEF,
        S_DRAIN,
        S_FINAL,
        S_FWAIT,
        S_EMIT
    } state_t;

    state_t                          state_reg, state_next;
    tdr_pkg::q16_t                   e_reg, e_next;
    logic [RW-1:0]                   idx_reg, idx_next;
    logic                            pend_reg, pend_next;
    logic [RW-1:0]                   regime_reg, regime_next;
    logic [TW-1:0]                   t_reg, t_next;
    logic                            a_vld_reg, a_vld_next;
    tdr_pkg::q16_t                   opnd_reg, opnd_next;
    tdr_pkg::q16_t                   mu_reg, mu_next;
    tdr_pkg::q16_t                   x_reg, x_next;
    tdr_pkg::q16_t                   dh_reg [MAX_P];
    tdr_pkg::q16_t                   dh_next [MAX_P];
    tdr_pkg::q16_t                   mh_reg [MAX_Q];
    tdr_pkg::q16_t                   mh_next [MAX_Q];
    logic [tdr_pkg::COUNT_W-1:0]     pos_reg, pos_next;
    logic [tdr_pkg::COUNT_W-1:0]     emit_cnt_reg, emit_cnt_next;
    logic                            out_vld_reg, out_vld_next;
    tdr_pkg::q16_t                   out_dur_reg, out_dur_next;
    logic [tdr_pkg::REGIME_W-1:0]    out_regime_reg, out_regime_next;
    logic                            out_last_reg, out_last_next;

    logic [tdr_pkg::ORDER_W-1:0]     order_p_reg;
    logic [tdr_pkg::ORDER_W-1:0]     order_q_reg;
    logic [tdr_pkg::ORDER_W-1:0]     bp_count_reg;
    logic [tdr_pkg::BURN_W-1:0]      burn_reg;
    logic [tdr_pkg::COUNT_W-1:0]     out_count_reg;

    logic [PW-1:0]                   p_eff;
    logic [QW-1:0]                   q_eff;
    logic [RW-1:0]                   nb_eff;
    logic [TW-1:0]                   n_terms;

    logic                            accept;
    logic                            out_free;
    logic                            coef_we;
    logic [CAW-1:0]                  coef_waddr;
    logic [CAW-1:0]                  coef_raddr;
    logic [tdr_pkg::VAL_W-1:0]       coef_rdata;
    logic                            bp_we;
    logic [BAW-1:0]                  bp_waddr;
    logic [BAW-1:0]                  bp_raddr;
    logic [tdr_pkg::VAL_W-1:0]       bp_rdata;
    tdr_pkg::q16_t                   opnd_sel;
    logic                            bp_issue;
    logic                            emit;

    tdr_pkg::mac_ctl_t               mac_ctl;
    tdr_pkg::q16_t                   mac_a;
    tdr_pkg::q16_t                   mac_b;
    logic signed [tdr_pkg::ACC_W-1:0] mac_acc;
    logic signed [tdr_pkg::RND_W-1:0] mac_rnd;
    logic                            mac_prod_vld;

    // effective orders
    assign p_eff   = (32'(order_p_reg) > MAX_P) ? PW'(MAX_P) : PW'(order_p_reg);
    assign q_eff   = (32'(order_q_reg) > MAX_Q) ? QW'(MAX_Q) : QW'(order_q_reg);
    assign nb_eff  = (32'(bp_count_reg) > MAX_BREAKPOINTS) ? RW'(MAX_BREAKPOINTS)
                                                           : RW'(bp_count_reg);
    assign n_terms = TW'(1) + TW'(p_eff) + TW'(q_eff);

    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign accept     = item.valid && item.ready;
    assign out_free   = !out_vld_reg || result.ready;

    assign result.valid       = out_vld_reg;
    assign result.duration    = out_dur_reg;
    assign result.regime      = out_regime_reg;
    assign result.last_result = out_last_reg;

    // table writes
    always_comb
    begin
        int off;
        logic ok;
        off = 0;
        ok  = 1'b0;
        if (32'(item.slot) < REGIMES)
        begin
            if (item.coef_kind == tdr_pkg::KIND_OMEGA)
            begin
                ok  = 1'b1;
                off = 0;
            end
            else if (item.coef_kind == tdr_pkg::KIND_ALPHA)
            begin
                ok  = (32'(item.lag) < MAX_P);
                off = 1 + int'(item.lag);
            end
            else if (item.coef_kind == tdr_pkg::KIND_BETA)
            begin
                ok  = (32'(item.lag) < MAX_Q);
                off = 1 + MAX_P + int'(item.lag);
            end
        end
        coef_we    = accept && (item.opcode == tdr_pkg::OP_LOAD_COEF) && ok;
        coef_waddr = CAW'(int'(item.slot) * PER_REGIME + off);
        bp_we      = accept && (item.opcode == tdr_pkg::OP_LOAD_BP)
                     && (32'(item.slot) < MAX_BREAKPOINTS);
        bp_waddr   = BAW'(item.slot);
    end

    // coefficient read address and history operand for term t
    always_comb
    begin
        int off;
        if (t_reg == '0)
            off = 0;
        else if (int'(t_reg) <= int'(p_eff))
            off = int'(t_reg);
        else
            off = int'(t_reg) - int'(p_eff) + MAX_P;
        coef_raddr = CAW'(int'(regime_reg) * PER_REGIME + off);
        bp_raddr   = BAW'(idx_reg);

        opnd_sel = tdr_pkg::ONE_Q16;
        for (int j = 0; j < MAX_P; j++)
        begin
            if (int'(t_reg) == j + 1)
                opnd_sel = dh_reg[j];
        end
        for (int j = 0; j < MAX_Q; j++)
        begin
            if (int'(t_reg) == int'(p_eff) + 1 + j)
                opnd_sel = mh_reg[j];
        end
    end

    assign mac_ctl.clear   = (state_reg == S_BP);
    assign mac_ctl.mul_vld = a_vld_reg || (state_reg == S_FINAL);
    assign mac_a           = (state_reg == S_FINAL) ? mu_reg : tdr_pkg::q16_t'(coef_rdata);
    assign mac_b           = (state_reg == S_FINAL) ? e_reg : opnd_reg;

    assign bp_issue = (idx_reg < nb_eff);
    assign emit     = (pos_reg >= tdr_pkg::COUNT_W'(burn_reg)) && (emit_cnt_reg < out_count_reg);

    always_comb
    begin
        state_next      = state_reg;
        e_next          = e_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        regime_next     = regime_reg;
        t_next          = t_reg;
        a_vld_next      = 1'b0;
        opnd_next       = opnd_reg;
        mu_next         = mu_reg;
        x_next          = x_reg;
        dh_next         = dh_reg;
        mh_next         = mh_reg;
        pos_next        = pos_reg;
        emit_cnt_next   = emit_cnt_reg;
        out_vld_next    = out_vld_reg && !result.ready;
        out_dur_next    = out_dur_reg;
        out_regime_next = out_regime_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.opcode)
                        tdr_pkg::OP_LOAD_COEF,
                        tdr_pkg::OP_LOAD_BP:
                        begin
                            state_next = S_IDLE;
                        end
                        tdr_pkg::OP_PUSH:
                        begin
                            x_next      = item.value_a;
                            mu_next     = item.value_b;
                            regime_next = '0;
                            state_next  = S_EMIT;
                        end
                        tdr_pkg::OP_STEP:
                        begin
                            e_next      = item.value_a;
                            idx_next    = '0;
                            pend_next   = 1'b0;
                            regime_next = '0;
                            state_next  = S_BP;
                        end
                    endcase
                end
            end
            S_BP:
            begin
                if (bp_issue)
                    idx_next = idx_reg + RW'(1);
                pend_next = bp_issue;
                if (pend_reg && (signed'(bp_rdata) <= dh_reg[0]))
                    regime_next = regime_reg + RW'(1);
                if (!bp_issue && !pend_reg)
                begin
                    t_next     = '0;
                    state_next = S_COEF;
                end
            end
            S_COEF:
            begin
                a_vld_next = 1'b1;
                opnd_next  = opnd_sel;
                t_next     = t_reg + TW'(1);
                if (t_reg == n_terms - TW'(1))
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!a_vld_reg && !mac_prod_vld)
                begin
                    mu_next    = tdr_pkg::sat_q16(mac_acc);
                    state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                state_next = S_FWAIT;
            end
            S_FWAIT:
            begin
                if (mac_prod_vld)
                begin
                    x_next     = tdr_pkg::sat_q16(tdr_pkg::ACC_W'(mac_rnd));
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!emit || out_free)
                begin
                    for (int j = MAX_P - 1; j > 0; j--)
                        dh_next[j] = dh_reg[j-1];
                    dh_next[0] = x_reg;
                    for (int j = MAX_Q - 1; j > 0; j--)
                        mh_next[j] = mh_reg[j-1];
                    mh_next[0] = mu_reg;
                    if (pos_reg != '1)
                        pos_next = pos_reg + tdr_pkg::COUNT_W'(1);
                    if (emit)
                    begin
                        emit_cnt_next   = emit_cnt_reg + tdr_pkg::COUNT_W'(1);
                        out_vld_next    = 1'b1;
                        out_dur_next    = x_reg;
                        out_regime_next = tdr_pkg::REGIME_W'(regime_reg);
                        out_last_next   = (emit_cnt_reg + tdr_pkg::COUNT_W'(1)) == out_count_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            e_reg          <= '0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            regime_reg     <= '0;
            t_reg          <= '0;
            a_vld_reg      <= 1'b0;
            opnd_reg       <= '0;
            mu_reg         <= '0;
            x_reg          <= '0;
            for (int j = 0; j < MAX_P; j++)
                dh_reg[j] <= '0;
            for (int j = 0; j < MAX_Q; j++)
                mh_reg[j] <= '0;
            pos_reg        <= '0;
            emit_cnt_reg   <= '0;
            out_vld_reg    <= 1'b0;
            out_dur_reg    <= '0;
            out_regime_reg <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            e_reg          <= e_next;
            idx_reg        <= idx_next;
            pend_reg       <= pend_next;
            regime_reg     <= regime_next;
            t_reg          <= t_next;
            a_vld_reg      <= a_vld_next;
            opnd_reg       <= opnd_next;
            mu_reg         <= mu_next;
            x_reg          <= x_next;
            dh_reg         <= dh_next;
            mh_reg         <= mh_next;
            pos_reg        <= pos_next;
            emit_cnt_reg   <= emit_cnt_next;
            out_vld_reg    <= out_vld_next;
            out_dur_reg    <= out_dur_next;
            out_regime_reg <= out_regime_next;
            out_last_reg   <= out_last_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_p_reg   <= tdr_pkg::ORDER_W'(1);
            order_q_reg   <= tdr_pkg::ORDER_W'(1);
            bp_count_reg  <= tdr_pkg::ORDER_W'(1);
            burn_reg      <= '0;
            out_count_reg <= tdr_pkg::COUNT_W'(1);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                tdr_pkg::CFG_ORDER_P:      order_p_reg   <= cfg.data[tdr_pkg::ORDER_W-1:0];
                tdr_pkg::CFG_ORDER_Q:      order_q_reg   <= cfg.data[tdr_pkg::ORDER_W-1:0];
                tdr_pkg::CFG_BP_COUNT:     bp_count_reg  <= cfg.data[tdr_pkg::ORDER_W-1:0];
                tdr_pkg::CFG_BURN_COUNT:   burn_reg      <= cfg.data[tdr_pkg::BURN_W-1:0];
                tdr_pkg::CFG_OUTPUT_COUNT: out_count_reg <= cfg.data[tdr_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    tdr_ram #(
        .WIDTH (tdr_pkg::VAL_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (item.value_a),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    tdr_ram #(
        .WIDTH (tdr_pkg::VAL_W),
        .DEPTH (MAX_BREAKPOINTS)
    ) u_bp_ram (
        .clk   (clk),
        .we    (bp_we),
        .waddr (bp_waddr),
        .wdata (item.value_a),
        .raddr (bp_raddr),
        .rdata (bp_rdata)
    );

    tdr_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mac_ctl),
        .a        (mac_a),
        .b        (mac_b),
        .acc      (mac_acc),
        .rnd      (mac_rnd),
        .prod_vld (mac_prod_vld)
    );

endmodule

`default_nettype wire

/* rtl/core/tdr_checker.sv */
// ----------------------------------------------------------------------------
// tdr_checker
// Port-level assertions for the threshold duration recursion core, bound
// to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tdr_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             item_valid,
    input wire logic                             item_ready,
    input wire logic [tdr_pkg::OP_W-1:0]         item_opcode,
    input wire logic                             result_valid,
    input wire logic                             result_ready,
    input wire logic signed [tdr_pkg::VAL_W-1:0] result_duration,
    input wire logic [tdr_pkg::REGIME_W-1:0]     result_regime,
    input wire logic                             result_last
);

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_duration) && $stable(result_regime)
            && $stable(result_last))
        else $error("result beat changed while stalled");

    // a step keeps the core busy past its accept cycle
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_opcode == tdr_pkg::OP_STEP) |=> !item_ready)
        else $error("item ready right after a step beat");

    // nothing follows the last result immediately
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && result_last |=> !result_valid)
        else $error("result beat right after last result");

    // no result while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result valid during reset");

endmodule

bind threshold_duration_recursion_core tdr_checker u_tdr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .item_opcode     (item.opcode),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_duration (result.duration),
    .result_regime   (result.regime),
    .result_last     (result.last_result)
);

`default_nettype wire
